// ----- design/lgm_pkg.sv -----
`default_nettype none
package lgm_pkg;

	localparam int SITES       = 1024;
	localparam int SITE_W      = $clog2(SITES);
	localparam int NSLOTS      = 256;
	localparam int SLOT_W      = $clog2(NSLOTS);
	localparam int NB_AW       = SITE_W + SLOT_W;
	localparam int LIM_W       = 9;
	localparam int EXP_TABLE   = 256;
	localparam int EXP_W       = $clog2(EXP_TABLE);
	localparam int ACC_W       = 40;
	localparam int DE_W        = 40;
	localparam int TOT_W       = 48;
	localparam int CNT_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 26;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [63:0] LN2_Q60   = 64'h0B17217F7D1CF79B;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_TRIAL = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MU     = 2'd0,
		CFG_BETA   = 2'd1,
		CFG_OFFSET = 2'd2,
		CFG_SLOTS  = 2'd3
	} cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic nb_write;
		logic site_read;
		logic was_load;
		logic scan_issue;
		logic sum_calc;
		logic diff_calc;
		logic mul1;
		logic mul2;
		logic decide;
		logic commit;
		logic out_load;
		logic clr_step;
		logic clr_full;
	} lgm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       lim_zero;
		logic       scan_last;
		logic       pipe_busy;
		logic       clr_last;
		logic       out_free;
	} lgm_status_t;

	typedef logic [32:0] exp_rom_t [EXP_TABLE];

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] pr;
		pr = {64'd0, a} * {64'd0, b};
		return pr[123:60];
	endfunction

	// shift and subtract quotient, only for building the table
	function automatic logic [63:0] div_small(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo, rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// 2^(-i/EXP_TABLE) in Q1.32, from a series for exp
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t   rom;
		logic [63:0] q, r, z, sum, term, k64;
		logic        done;
		q = LN2_Q60 / EXP_TABLE;
		r = LN2_Q60 % EXP_TABLE;
		for (int i = 0; i < EXP_TABLE; i++) begin
			z    = q * 64'(i) + (r * 64'(i)) / EXP_TABLE;
			sum  = 64'd1 << 60;
			term = 64'd1 << 60;
			done = 1'b0;
			for (int k = 1; k < 40; k++) begin
				if (!done) begin
					k64  = 64'(k);
					term = div_small(mul_q60(term, z), k64);
					if (term == 64'd0)
						done = 1'b1;
					else if (k % 2 == 1)
						sum = sum - term;
					else
						sum = sum + term;
				end
			end
			sum    = (sum + (64'd1 << 27)) >> 28;
			rom[i] = sum[32:0];
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage
`default_nettype wire

// ----- design/lgm_if.sv -----
`default_nettype none
interface lgm_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [9:0]         site;
	logic [7:0]         slot;
	logic [9:0]         neighbor_site;
	logic signed [31:0] pair_energy;
	logic [31:0]        uniform_word;
	modport source(output valid, kind, site, slot, neighbor_site, pair_energy, uniform_word,
		input ready);
	modport sink(input valid, kind, site, slot, neighbor_site, pair_energy, uniform_word,
		output ready);
endinterface

interface lgm_result_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic               site_occupied;
	logic signed [39:0] energy_change;
	logic signed [47:0] total_energy;
	logic [10:0]        particle_count;
	modport source(output valid, accepted, site_occupied, energy_change, total_energy,
		particle_count, input ready);
	modport sink(input valid, accepted, site_occupied, energy_change, total_energy,
		particle_count, output ready);
endinterface

interface lgm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [25:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/lgm_ctrl.sv -----
`default_nettype none
module lgm_ctrl
	import lgm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire lgm_status_t status,
	output lgm_cmd_t         cmd
);

	typedef enum logic [13:0] {
		ST_INIT   = 14'b00000000000001,
		ST_IDLE   = 14'b00000000000010,
		ST_SITE   = 14'b00000000000100,
		ST_SITE2  = 14'b00000000001000,
		ST_SCAN   = 14'b00000000010000,
		ST_DRAIN  = 14'b00000000100000,
		ST_SUM    = 14'b00000001000000,
		ST_DIFF   = 14'b00000010000000,
		ST_MUL1   = 14'b00000100000000,
		ST_MUL2   = 14'b00001000000000,
		ST_DECIDE = 14'b00010000000000,
		ST_COMMIT = 14'b00100000000000,
		ST_CLEAR  = 14'b01000000000000,
		ST_FINISH = 14'b10000000000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_nxt;
	end

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				cmd.clr_full = 1'b1;
				if (status.clr_last)
					state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_SITE;
				end
			end
			ST_SITE: begin
				cmd.site_read = 1'b1;
				cmd.nb_write  = (status.kind == KIND_LOAD);
				state_nxt     = (status.kind == KIND_CLEAR) ? ST_CLEAR : ST_SITE2;
			end
			ST_SITE2: begin
				cmd.was_load = 1'b1;
				if (status.kind != KIND_TRIAL)
					state_nxt = ST_FINISH;
				else if (status.lim_zero)
					state_nxt = ST_SUM;
				else
					state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.scan_last)
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy)
					state_nxt = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_calc = 1'b1;
				state_nxt    = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff_calc = 1'b1;
				state_nxt     = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1  = 1'b1;
				state_nxt = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_nxt  = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = ST_FINISH;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last)
					state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_INIT;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/lgm_datapath.sv -----
`default_nettype none
module lgm_datapath
	import lgm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lgm_cmd_t               cmd,
	output lgm_status_t                 status,
	input  wire logic [1:0]             in_kind,
	input  wire logic [SITE_W-1:0]      in_site,
	input  wire logic [SLOT_W-1:0]      in_slot,
	input  wire logic [SITE_W-1:0]      in_nsite,
	input  wire logic signed [31:0]     in_energy,
	input  wire logic [31:0]            in_word,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   out_ready,
	output logic                        out_valid,
	output logic                        out_accepted,
	output logic                        out_occupied,
	output logic signed [DE_W-1:0]      out_de,
	output logic signed [TOT_W-1:0]     out_total,
	output logic [CNT_W-1:0]            out_count
);

	typedef struct packed {
		logic [SITE_W-1:0] idx;
		logic [31:0]       energy;
	} nb_entry_t;

	// configuration
	logic signed [25:0] mu_q, offset_q;
	logic [23:0]        beta_q;
	logic [LIM_W-1:0]   slots_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q     <= -26'sd2516582;
			beta_q   <= 24'd2569288;
			offset_q <= -26'sd503264;
			slots_q  <= 9'd182;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MU:     mu_q     <= cfg_data;
				CFG_BETA:   beta_q   <= cfg_data[23:0];
				CFG_OFFSET: offset_q <= cfg_data;
				CFG_SLOTS:  slots_q  <= cfg_data[LIM_W-1:0];
				default:    ;
			endcase
		end
	end

	logic [LIM_W-1:0] lim;
	assign lim = (slots_q > LIM_W'(NSLOTS)) ? LIM_W'(NSLOTS) : slots_q;

	// captured item
	logic [1:0]         kind_q;
	logic [SITE_W-1:0]  site_q, nsite_q;
	logic [SLOT_W-1:0]  slot_q;
	logic signed [31:0] pe_q;
	logic [31:0]        word_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= in_kind;
			site_q  <= in_site;
			slot_q  <= in_slot;
			nsite_q <= in_nsite;
			pe_q    <= in_energy;
			word_q  <= in_word;
		end
	end

	// clearing sweep counter
	logic [NB_AW-1:0] clr_q;
	logic             clr_last;
	assign clr_last = cmd.clr_full ? (&clr_q) : (&clr_q[SITE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_step)
			clr_q <= clr_last ? '0 : clr_q + 1'b1;
	end

	// neighbor table
	nb_entry_t        nb_mem [SITES*NSLOTS];
	nb_entry_t        nb_rd_q;
	logic [LIM_W-1:0] n_q;
	logic [NB_AW-1:0] nb_waddr;
	nb_entry_t        nb_wdata;
	logic             nb_we;

	assign nb_we    = cmd.nb_write | cmd.clr_full;
	assign nb_waddr = cmd.clr_full ? clr_q : {site_q, slot_q};
	assign nb_wdata = cmd.clr_full ? '0 : nb_entry_t'{idx: nsite_q, energy: pe_q};

	always_ff @(posedge clk) begin
		if (nb_we)
			nb_mem[nb_waddr] <= nb_wdata;
		nb_rd_q <= nb_mem[{site_q, n_q[SLOT_W-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			n_q <= '0;
		else if (cmd.was_load)
			n_q <= '0;
		else if (cmd.scan_issue)
			n_q <= n_q + 1'b1;
	end

	// occupancy
	logic              occ_mem [SITES];
	logic              occ_rd_q;
	logic [SITE_W-1:0] occ_raddr, occ_waddr;
	logic              occ_we, occ_wdata;
	logic              was_q, acc_q;

	assign occ_raddr = cmd.site_read ? site_q : nb_rd_q.idx;
	assign occ_we    = cmd.clr_step | (cmd.commit & acc_q);
	assign occ_waddr = cmd.clr_step ? clr_q[SITE_W-1:0] : site_q;
	assign occ_wdata = cmd.clr_step ? 1'b0 : ~was_q;

	always_ff @(posedge clk) begin
		if (occ_we)
			occ_mem[occ_waddr] <= occ_wdata;
		occ_rd_q <= occ_mem[occ_raddr];
	end

	// scan pipeline: slot read, occupancy read, accumulate
	logic                    v_s1, v_s2;
	logic signed [31:0]      energy_s2;
	logic signed [ACC_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		energy_s2 <= nb_rd_q.energy;
		if (cmd.was_load)
			was_q <= occ_rd_q;
		if (cmd.was_load)
			sum_q <= '0;
		else if (v_s2 && occ_rd_q)
			sum_q <= sum_q + ACC_W'(energy_s2);
	end

	// energy change and acceptance
	logic signed [ACC_W:0]   s_full;
	logic signed [ACC_W+1:0] s_signed;
	logic signed [DE_W-1:0]  de_sat, de_q;
	logic signed [DE_W:0]    d_full;
	logic [DE_W-1:0]         d_q;
	logic                    dpos_q, big_q;
	logic [63:0]             p_q;
	logic [60:0]             y_q;
	logic [6:0]              exp_n;
	logic [EXP_W-1:0]        exp_idx;
	logic [32:0]             prob;

	localparam logic signed [ACC_W+1:0] DE_HI = (ACC_W+2)'((64'sd1 <<< (DE_W-1)) - 1);
	localparam logic signed [ACC_W+1:0] DE_LO = -DE_HI - (ACC_W+2)'(1);

	assign s_full   = (ACC_W+1)'(sum_q) + (ACC_W+1)'(offset_q);
	assign s_signed = was_q ? -(ACC_W+2)'(s_full) : (ACC_W+2)'(s_full);
	assign de_sat   = (s_signed > DE_HI) ? DE_HI[DE_W-1:0] :
		(s_signed < DE_LO) ? DE_LO[DE_W-1:0] : s_signed[DE_W-1:0];
	assign d_full   = was_q ? ((DE_W+1)'(de_q) + (DE_W+1)'(mu_q))
		: ((DE_W+1)'(de_q) - (DE_W+1)'(mu_q));

	assign exp_n   = y_q[60:54];
	assign exp_idx = y_q[53:54-EXP_W];
	assign prob    = (big_q || exp_n[6]) ? 33'd0 : (EXP_ROM[exp_idx] >> exp_n);

	always_ff @(posedge clk) begin
		if (cmd.sum_calc)
			de_q <= de_sat;
		if (cmd.diff_calc) begin
			d_q    <= d_full[DE_W-1:0];
			dpos_q <= !d_full[DE_W] && (d_full != '0);
		end
		if (cmd.mul1)
			p_q <= {24'd0, d_q} * {40'd0, beta_q};
		if (cmd.mul2) begin
			big_q <= |p_q[63:46];
			y_q   <= {31'd0, p_q[45:16]} * {30'd0, LOG2E_Q30};
		end
		if (cmd.decide)
			acc_q <= !dpos_q || ({1'b0, word_q} <= prob);
	end

	// totals
	logic signed [TOT_W-1:0] total_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [TOT_W:0]   total_sum;
	localparam logic signed [TOT_W:0] TOT_HI = (TOT_W+1)'((64'sd1 <<< (TOT_W-1)) - 1);
	localparam logic signed [TOT_W:0] TOT_LO = -TOT_HI - (TOT_W+1)'(1);

	assign total_sum = (TOT_W+1)'(total_q) + (TOT_W+1)'(de_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
		end else if (cmd.clr_step && !cmd.clr_full) begin
			total_q <= '0;
			count_q <= '0;
		end else if (cmd.commit && acc_q) begin
			total_q <= (total_sum > TOT_HI) ? TOT_HI[TOT_W-1:0] :
				(total_sum < TOT_LO) ? TOT_LO[TOT_W-1:0] : total_sum[TOT_W-1:0];
			if (was_q) begin
				if (count_q != '0)
					count_q <= count_q - 1'b1;
			end else if (count_q != CNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// result register
	logic out_valid_q;
	logic is_trial;
	assign is_trial = (kind_q == KIND_TRIAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_accepted <= is_trial & acc_q;
			out_occupied <= (kind_q == KIND_CLEAR) ? 1'b0 : (is_trial ? (was_q ^ acc_q) : was_q);
			out_de       <= is_trial ? de_q : '0;
			out_total    <= total_q;
			out_count    <= count_q;
		end
	end

	assign out_valid = out_valid_q;

	assign status.kind      = kind_q;
	assign status.lim_zero  = (lim == '0);
	assign status.scan_last = (n_q + 1'b1 == lim);
	assign status.pipe_busy = v_s1 | v_s2;
	assign status.clr_last  = clr_last;
	assign status.out_free  = !out_valid_q || out_ready;

endmodule
`default_nettype wire

// ----- design/lattice_gas_metropolis_step.sv -----
`default_nettype none
// Grand-canonical lattice gas, one Metropolis insertion or removal trial per item. Load items
// write one neighbor slot and clear items empty the lattice; each returns one result beat.
// After reset the block sweeps the whole neighbor table to zero, one slot a cycle, before
// the first item is taken; configuration writes are taken throughout. A trial scans
// min(neighbor_slots_in_use, 256) slots through the neighbor table, one a cycle. Loads and
// unused kinds skip the scan, and a clear sweeps the occupancy memory to zero.
// A finished result waits in the output register while the next item is accepted.
module lattice_gas_metropolis_step
	import lgm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	lgm_item_if.sink     item,
	lgm_result_if.source result,
	lgm_cfg_if.sink      cfg
);

	lgm_cmd_t    cmd;
	lgm_status_t status;

	assign cfg.ready = 1'b1;

	lgm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	lgm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_kind      (item.kind),
		.in_site      (item.site),
		.in_slot      (item.slot),
		.in_nsite     (item.neighbor_site),
		.in_energy    (item.pair_energy),
		.in_word      (item.uniform_word),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.out_accepted (result.accepted),
		.out_occupied (result.site_occupied),
		.out_de       (result.energy_change),
		.out_total    (result.total_energy),
		.out_count    (result.particle_count)
	);

endmodule
`default_nettype wire
